// ===== hw/rtl/aeau_pkg.sv =====
// ----------------------------------------------------------------------------
// aeau_pkg
// Types and codes shared by the array element address unit.
// ----------------------------------------------------------------------------
package aeau_pkg;

	// input item kinds
	localparam logic [1:0] KIND_HEADER = 2'd0;
	localparam logic [1:0] KIND_BOUND  = 2'd1;
	localparam logic [1:0] KIND_QUERY  = 2'd2;

	// classified operations passed from front to back
	localparam logic [1:0] OP_HEADER    = 2'd0;
	localparam logic [1:0] OP_BOUND     = 2'd1;
	localparam logic [1:0] OP_QUERY     = 2'd2;
	localparam logic [1:0] OP_QUERY_BAD = 2'd3;

	localparam logic STATUS_OK    = 1'b0;
	localparam logic STATUS_UNDEF = 1'b1;

	localparam int ID_W = 10;

	typedef struct packed {
		logic [1:0]         kind;
		logic [ID_W-1:0]    array_id;
		logic [3:0]         dim_index;
		logic signed [31:0] base_address;
		logic [15:0]        elem_size;
		logic [4:0]         dim_count;
		logic signed [15:0] lower_bound;
		logic signed [15:0] upper_bound;
		logic signed [15:0] position;
	} aeau_in_t;

	typedef struct packed {
		logic signed [31:0] address;
		logic               status;
		logic [ID_W-1:0]    query_id;
	} aeau_out_t;

	typedef struct packed {
		logic [1:0] op;
		aeau_in_t   item;
	} aeau_cmd_t;

endpackage

// ===== hw/rtl/aeau_front.sv =====
// ----------------------------------------------------------------------------
// aeau_front
// Takes input items, classifies them, drops invalid headers and bounds and queues the rest for the back end.
// ----------------------------------------------------------------------------
module aeau_front #(
	parameter int ARRAY_SLOTS = 1024,
	parameter int MAX_DIMS    = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  aeau_pkg::aeau_in_t item,
	input  logic               clearing,
	output logic               busy,
	output logic               cmd_valid,
	output aeau_pkg::aeau_cmd_t cmd,
	input  logic               cmd_take
);
	import aeau_pkg::*;

	aeau_cmd_t  q_mem [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	logic       accept;
	logic       keep;
	logic       push;
	logic       pop;
	logic       id_ok;
	logic       dim_ok;
	logic [1:0] op;

	assign busy   = (count_q == 2'd2) || clearing;
	assign accept = start && !busy;

	assign id_ok  = {22'd0, item.array_id} < 32'(ARRAY_SLOTS);
	assign dim_ok = {28'd0, item.dim_index} < 32'(MAX_DIMS);

	always_comb begin
		keep = 1'b0;
		op   = OP_HEADER;
		case (item.kind)
			KIND_HEADER: begin
				keep = id_ok;
				op   = OP_HEADER;
			end
			KIND_BOUND: begin
				keep = id_ok && dim_ok;
				op   = OP_BOUND;
			end
			KIND_QUERY: begin
				keep = 1'b1;
				op   = id_ok ? OP_QUERY : OP_QUERY_BAD;
			end
			default: begin
				keep = 1'b0;
				op   = OP_HEADER;
			end
		endcase
	end

	assign push      = accept && keep;
	assign pop       = cmd_take && cmd_valid;
	assign cmd_valid = count_q != 2'd0;
	assign cmd       = q_mem[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wr_ptr_q].op   <= op;
			q_mem[wr_ptr_q].item <= item;
		end
	end

endmodule

// ===== hw/rtl/aeau_back.sv =====
// ----------------------------------------------------------------------------
// aeau_back
// Descriptor and bound tables plus the offset sequencer that answers queries.
// ----------------------------------------------------------------------------
module aeau_back #(
	parameter int ARRAY_SLOTS = 1024,
	parameter int MAX_DIMS    = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	input  aeau_pkg::aeau_cmd_t cmd,
	output logic                cmd_take,
	output logic                clearing,
	output logic                result_valid,
	output aeau_pkg::aeau_out_t result
);
	import aeau_pkg::*;

	localparam int SLOT_W    = (ARRAY_SLOTS > 1) ? $clog2(ARRAY_SLOTS) : 1;
	localparam int DIM_W     = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
	localparam int IDX_W     = (SLOT_W > ID_W) ? SLOT_W : ID_W;
	localparam int BND_DEPTH = ARRAY_SLOTS * (1 << DIM_W);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_EVAL  = 3'd2;
	localparam logic [2:0] ST_ACC   = 3'd3;
	localparam logic [2:0] ST_SCALE = 3'd4;

	typedef struct packed {
		logic        defined;
		logic [31:0] base;
		logic [15:0] size;
		logic [4:0]  count;
	} slot_t;

	typedef struct packed {
		logic [15:0] lower;
		logic [15:0] upper;
	} bnd_t;

	slot_t slot_mem [ARRAY_SLOTS];
	bnd_t  bnd_mem  [BND_DEPTH];

	logic [2:0]        state_q;
	logic [SLOT_W-1:0] clr_q;
	slot_t             slot_rd_q;
	bnd_t              bnd_rd_q;
	logic              bad_q;
	logic [3:0]        dim_q;
	logic [ID_W-1:0]   id_q;
	logic [15:0]       pos_q;
	logic [31:0]       offset_q;
	logic [31:0]       diff_q;
	logic [31:0]       ext_q;
	logic              first_q;
	logic              last_q;
	logic              result_valid_q;
	aeau_out_t         result_q;

	logic [IDX_W-1:0]        id_ext;
	logic [SLOT_W-1:0]       slot_idx;
	logic [SLOT_W+DIM_W-1:0] bnd_idx;
	logic                    take;
	logic [4:0]              count_eff;
	logic [31:0]             lo_ext;
	logic [31:0]             hi_ext;
	logic [31:0]             pos_ext;
	logic [31:0]             mac;

	assign id_ext   = IDX_W'(cmd.item.array_id);
	assign slot_idx = id_ext[SLOT_W-1:0];
	assign bnd_idx  = {slot_idx, cmd.item.dim_index[DIM_W-1:0]};

	assign clearing = state_q == ST_CLEAR;
	assign cmd_take = (state_q == ST_IDLE) && cmd_valid;
	assign take     = cmd_take;

	// stored count 0 acts as 1, above the limit acts as the limit
	always_comb begin
		count_eff = slot_rd_q.count;
		if (slot_rd_q.count == 5'd0)
			count_eff = 5'd1;
		else if (slot_rd_q.count > 5'(MAX_DIMS))
			count_eff = 5'(MAX_DIMS);
	end

	assign lo_ext  = {{16{bnd_rd_q.lower[15]}}, bnd_rd_q.lower};
	assign hi_ext  = {{16{bnd_rd_q.upper[15]}}, bnd_rd_q.upper};
	assign pos_ext = {{16{pos_q[15]}}, pos_q};
	assign mac     = (first_q ? 32'd0 : offset_q * ext_q) + diff_q;

	// tables; the clear pass marks every slot undefined after reset
	always_ff @(posedge clk) begin
		if (state_q == ST_CLEAR)
			slot_mem[clr_q] <= '0;
		else if (take && cmd.op == OP_HEADER)
			slot_mem[slot_idx] <= '{defined: 1'b1,
				base: cmd.item.base_address,
				size: cmd.item.elem_size,
				count: cmd.item.dim_count};
		if (take && cmd.op == OP_BOUND)
			bnd_mem[bnd_idx] <= '{lower: cmd.item.lower_bound,
				upper: cmd.item.upper_bound};
		if (take && cmd.op == OP_QUERY) begin
			slot_rd_q <= slot_mem[slot_idx];
			bnd_rd_q  <= bnd_mem[bnd_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			bad_q <= cmd.op == OP_QUERY_BAD;
			dim_q <= cmd.item.dim_index;
			id_q  <= cmd.item.array_id;
			pos_q <= cmd.item.position;
		end
		if (state_q == ST_EVAL) begin
			diff_q  <= pos_ext - lo_ext;
			ext_q   <= hi_ext - lo_ext + 32'd1;
			first_q <= dim_q == 4'd0;
			last_q  <= {1'b0, dim_q} == count_eff - 5'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_CLEAR;
			clr_q          <= '0;
			offset_q       <= 32'd0;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == SLOT_W'(ARRAY_SLOTS - 1))
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (take && (cmd.op == OP_QUERY || cmd.op == OP_QUERY_BAD))
						state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					if (bad_q || !slot_rd_q.defined) begin
						offset_q       <= 32'd0;
						result_valid_q <= 1'b1;
						state_q        <= ST_IDLE;
					end else if ({1'b0, dim_q} >= count_eff) begin
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_ACC;
					end
				end
				ST_ACC: begin
					offset_q <= mac;
					state_q  <= last_q ? ST_SCALE : ST_IDLE;
				end
				ST_SCALE: begin
					offset_q       <= 32'd0;
					result_valid_q <= 1'b1;
					state_q        <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EVAL) begin
			result_q.address  <= 32'sd0;
			result_q.status   <= STATUS_UNDEF;
			result_q.query_id <= id_q;
		end else if (state_q == ST_SCALE) begin
			result_q.address  <= slot_rd_q.base + offset_q * {16'd0, slot_rd_q.size};
			result_q.status   <= STATUS_OK;
			result_q.query_id <= id_q;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

// ===== hw/rtl/array_element_address_unit.sv =====
// ----------------------------------------------------------------------------
// array_element_address_unit
// Row-major element address calculation over a table of array descriptors.
// ----------------------------------------------------------------------------
// Input: an item transfers on a clock edge with start high and busy low.
// Header items define a slot (base, element size, dimension count), bound
// items set one dimension's lower/upper bounds, subscript items of a query
// must arrive in dimension order, which the block itself does not enforce.
// The back end writes headers and bounds while idle; a subscript passes the
// evaluate and accumulate states, and a query's last subscript also scale.
// Output: result_valid strobes for one cycle with address, status and id;
// the receiver cannot stall, so results are never held back. Undefined or
// out-of-range slots answer with error status from the evaluate state.
// With the queue empty, a strobe follows the queue entry and these states.
// A two-entry queue sits between the input classifier and the sequencer,
// so items are taken while earlier ones are still being worked off.
// After reset the block runs a clearing pass over every slot of the
// descriptor table, holding busy high; bounds are not cleared.
// ----------------------------------------------------------------------------
module array_element_address_unit #(
	parameter int ARRAY_SLOTS = 1024,
	parameter int MAX_DIMS    = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  aeau_pkg::aeau_in_t  item,
	output logic                result_valid,
	output aeau_pkg::aeau_out_t result
);
	import aeau_pkg::*;

	logic      cmd_valid;
	logic      cmd_take;
	logic      clearing;
	aeau_cmd_t cmd;

	aeau_front #(
		.ARRAY_SLOTS(ARRAY_SLOTS),
		.MAX_DIMS   (MAX_DIMS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.item     (item),
		.clearing (clearing),
		.busy     (busy),
		.cmd_valid(cmd_valid),
		.cmd      (cmd),
		.cmd_take (cmd_take)
	);

	aeau_back #(
		.ARRAY_SLOTS(ARRAY_SLOTS),
		.MAX_DIMS   (MAX_DIMS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd         (cmd),
		.cmd_take    (cmd_take),
		.clearing    (clearing),
		.result_valid(result_valid),
		.result      (result)
	);

	// no answers while the table is being cleared
	a_no_result_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !result_valid)
		else $error("result during clear pass");

	// every query passes through evaluation, so strobes never abut
	a_result_spaced: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("back-to-back result strobes");

	a_busy_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> busy)
		else $error("input open during clear pass");

	a_take_needs_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_take |-> cmd_valid && !clearing)
		else $error("queue popped while empty or clearing");

endmodule
